[src/cst_pkg.sv]
// Shared types, action codes and constants for the component statistics table.
`timescale 1ns / 1ps

package cst_pkg;

    // Action codes of the command beat; the fourth code behaves as a read.
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_ACCUM = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    // Largest image side that the bounds check admits.
    localparam int MAX_DIMENSION = 2048;

    localparam int DIM_W   = 12;
    localparam int COORD_W = 11;
    localparam int COUNT_W = 23;
    localparam int SUM_W   = 33;

    // One table entry as it is kept in the memory.
    typedef struct packed {
        logic [DIM_W-1:0]   min_x;
        logic [DIM_W-1:0]   max_x;
        logic [DIM_W-1:0]   min_y;
        logic [DIM_W-1:0]   max_y;
        logic [COUNT_W-1:0] count;
        logic [SUM_W-1:0]   col_sum;
        logic [SUM_W-1:0]   row_sum;
    } record_t;

    localparam int RECORD_W = $bits(record_t);

    // Command held while its entry is read back and updated.
    typedef struct packed {
        logic [1:0]         action;
        logic [9:0]         label;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [7:0]         value;
        logic               in_range;
    } cmd_t;

endpackage

[src/cst_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module cst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; read data is registered.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[src/cst_update.sv]
// Modify step: works out an entry's new record from the old one and the command.
`timescale 1ns / 1ps

module cst_update (
    input  cst_pkg::cmd_t              cmd,
    input  logic [cst_pkg::DIM_W-1:0]  image_width,
    input  logic [cst_pkg::DIM_W-1:0]  image_height,
    input  cst_pkg::record_t           old_rec,
    output cst_pkg::record_t           new_rec,
    output logic                       write_en
);

    import cst_pkg::*;

    logic            pixel_ok;
    logic [SUM_W:0]  col_total;
    logic [SUM_W:0]  row_total;
    logic [DIM_W-1:0] x_ext;
    logic [DIM_W-1:0] y_ext;

    assign x_ext = {1'b0, cmd.x};
    assign y_ext = {1'b0, cmd.y};

    // An object pixel counts only when it lies inside the image.
    assign pixel_ok = (cmd.value == 8'd0)
        && (x_ext < image_width) && (32'(cmd.x) < MAX_DIMENSION)
        && (y_ext < image_height) && (32'(cmd.y) < MAX_DIMENSION);

    // Sums carry one extra bit so that overflow shows as a carry.
    assign col_total = {1'b0, old_rec.col_sum} + (SUM_W + 1)'(cmd.x);
    assign row_total = {1'b0, old_rec.row_sum} + (SUM_W + 1)'(cmd.y);

    // Record after the action; every write is gated by the label check.
    always_comb
    begin
        new_rec  = old_rec;
        write_en = 1'b0;
        unique case (cmd.action)
            ACT_CLEAR:
            begin
                new_rec.min_x   = image_width;
                new_rec.min_y   = image_height;
                new_rec.max_x   = '1;
                new_rec.max_y   = '1;
                new_rec.count   = '0;
                new_rec.col_sum = '0;
                new_rec.row_sum = '0;
                write_en        = 1'b1;
            end
            ACT_ACCUM:
            begin
                if (pixel_ok)
                begin
                    if (x_ext < old_rec.min_x)
                    begin
                        new_rec.min_x = x_ext;
                    end
                    if ($signed(x_ext) > $signed(old_rec.max_x))
                    begin
                        new_rec.max_x = x_ext;
                    end
                    if (y_ext < old_rec.min_y)
                    begin
                        new_rec.min_y = y_ext;
                    end
                    if ($signed(y_ext) > $signed(old_rec.max_y))
                    begin
                        new_rec.max_y = y_ext;
                    end
                    if (old_rec.count != '1)
                    begin
                        new_rec.count = old_rec.count + COUNT_W'(1);
                    end
                    new_rec.col_sum = col_total[SUM_W] ? '1 : col_total[SUM_W-1:0];
                    new_rec.row_sum = row_total[SUM_W] ? '1 : row_total[SUM_W-1:0];
                    write_en        = 1'b1;
                end
            end
            default:
            begin
                // Read and the unused code leave the entry as it is.
                write_en = 1'b0;
            end
        endcase

        // A label beyond the table changes nothing and reports all zeros.
        if (!cmd.in_range)
        begin
            new_rec  = '0;
            write_en = 1'b0;
        end
    end

endmodule

[src/component_statistics_table.sv]
// Top level of the component statistics table: command sequencer, config and result.
//
//   channel   handshake                   payload
//   command   start in, busy out          action, label, pixel_x, pixel_y, pixel_value
//   config    cfg_valid in, cfg_ready out cfg_index, cfg_data
//   result    result_valid out            box_min_x .. row_sum
//
// Each command's entry is read from the table RAM in the cycle that accepts it and
// is modified and written back in S_UPDATE; its result beat follows in the next
// cycle. A new command is taken in the cycle of that result beat.
// Reset clears the sequencer, the strobe and sets the image size to 640 by 480;
// table entries hold nothing defined until cleared. The receiver cannot stall.
`timescale 1ns / 1ps

module component_statistics_table #(
    parameter int LABEL_COUNT = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          action,
    input  logic [9:0]                          label,
    input  logic [10:0]                         pixel_x,
    input  logic [10:0]                         pixel_y,
    input  logic [7:0]                          pixel_value,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cst_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [11:0]                         cfg_data,
    output logic                                result_valid,
    output logic [11:0]                         box_min_x,
    output logic signed [11:0]                  box_max_x,
    output logic [11:0]                         box_min_y,
    output logic signed [11:0]                  box_max_y,
    output logic [22:0]                         pixel_count,
    output logic [32:0]                         column_sum,
    output logic [32:0]                         row_sum
);

    import cst_pkg::*;

    localparam int ADDR_W = $clog2(LABEL_COUNT);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_UPDATE = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    cmd_t             cmd_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             strobe_reg;
    record_t          result_reg;

    logic             accept;
    record_t          old_rec;
    record_t          new_rec;
    logic             wr_en;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // Sequencer: lookup as the command is accepted in S_IDLE, then the update in S_UPDATE.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Command capture at acceptance.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg.action   <= action;
            cmd_reg.label    <= label;
            cmd_reg.x        <= pixel_x;
            cmd_reg.y        <= pixel_y;
            cmd_reg.value    <= pixel_value;
            cmd_reg.in_range <= (32'(label) < LABEL_COUNT);
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 12'd640;
            height_reg <= 12'd480;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    // Table memory holding every entry's record.
    cst_ram #(
        .WIDTH (RECORD_W),
        .DEPTH (LABEL_COUNT)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(cmd_reg.label)),
        .wr_data (new_rec),
        .rd_en   (accept),
        .rd_addr (ADDR_W'(label)),
        .rd_data (old_rec)
    );

    // Modify step on the entry just read.
    logic upd_write;

    cst_update u_update (
        .cmd          (cmd_reg),
        .image_width  (width_reg),
        .image_height (height_reg),
        .old_rec      (old_rec),
        .new_rec      (new_rec),
        .write_en     (upd_write)
    );

    assign wr_en = upd_write && (state_reg == S_UPDATE);

    // Result strobe and payload register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= (state_reg == S_UPDATE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_UPDATE)
        begin
            result_reg <= new_rec;
        end
    end

    assign result_valid = strobe_reg;
    assign box_min_x    = result_reg.min_x;
    assign box_max_x    = $signed(result_reg.max_x);
    assign box_min_y    = result_reg.min_y;
    assign box_max_y    = $signed(result_reg.max_y);
    assign pixel_count  = result_reg.count;
    assign column_sum   = result_reg.col_sum;
    assign row_sum      = result_reg.row_sum;

`ifndef NO_ASSERTIONS
    // An accepted command always occupies the sequencer in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> busy)
        else $error("accepted command did not raise busy");

    // The update occupies S_UPDATE only; the sequencer then returns to idle without waiting.
    assert property (@(posedge clk) disable iff (!rst_n) busy |=> !busy)
        else $error("busy held for more than one cycle");

    // A result beat follows each update and never overlaps one.
    assert property (@(posedge clk) disable iff (!rst_n) busy |=> result_valid)
        else $error("update produced no result beat");

    assert property (@(posedge clk) disable iff (!rst_n) result_valid |-> !busy)
        else $error("result beat during an update");

    // The table is written only in the update cycle.
    assert property (@(posedge clk) disable iff (!rst_n) wr_en |-> (state_reg == S_UPDATE))
        else $error("table written outside the update cycle");
`endif

endmodule
